>>> sv/fbp_pkg.sv
`default_nettype none

package fbp_pkg;

  // Default width of one signed component of a spectrum bin.
  localparam int COMPONENT_BITS_DEF = 32;

  // Port widths.
  localparam int IN_W    = 32;
  localparam int POWER_W = 16;
  localparam int PHASE_W = 16;

  // Power path: squared magnitude, Q1.31 mantissa and log2 in Q6.16.
  localparam int MAG_W  = 64;
  localparam int MANT_W = 32;
  localparam int EXP_W  = 6;
  localparam int FRAC_W = 16;
  localparam int LOG_W  = EXP_W + FRAC_W;

  // round(10*log10(2) * 2^24) and the rounding of the scaled product.
  localparam int DB_W      = 26;
  localparam int DB_PROD_W = LOG_W + DB_W;
  localparam int DB_DROP   = 32;
  localparam logic [DB_W-1:0]      DB_PER_LOG2_Q24 = 26'd50504453;
  localparam logic [DB_PROD_W-1:0] DB_ROUND        = 48'h0000_8000_0000;

  // Phase path: magnitude search width, shift count and CORDIC datapath.
  localparam int A_W     = 32;
  localparam int SHIFT_W = 5;
  localparam logic [SHIFT_W-1:0] NORM_TOP = 5'd30;
  localparam int CW           = 36;
  localparam int CORDIC_STEPS = 24;
  localparam int ACC_W        = 26;
  localparam int PH_DROP      = 8;
  localparam logic signed [ACC_W-1:0] ANGLE_PI  = 26'sd16777216;
  localparam logic signed [ACC_W-1:0] ACC_ROUND = 26'sd128;

  // Arctangent of 2^-i, with pi equal to 2^24.
  localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    26'sd4194304, 26'sd2476042, 26'sd1308273, 26'sd664100,
    26'sd333339,  26'sd166832,  26'sd83436,   26'sd41721,
    26'sd20861,   26'sd10430,   26'sd5215,    26'sd2608,
    26'sd1304,    26'sd652,     26'sd326,     26'sd163,
    26'sd81,      26'sd41,      26'sd20,      26'sd10,
    26'sd5,       26'sd3,       26'sd1,       26'sd1
  };

  // Pipeline depths of the two paths; the power result is delayed to match.
  localparam int PW_LAT = 5 + FRAC_W + 2;
  localparam int PH_LAT = 5 + CORDIC_STEPS + 1;
  localparam int PAD    = PH_LAT - PW_LAT;

  // What the phase path hands to the top level.
  typedef struct packed {
    logic                      zero_mag;
    logic                      last;
    logic signed [PHASE_W-1:0] phase;
  } fbp_ph_res_t;

  // One finished result item.
  typedef struct packed {
    logic [POWER_W-1:0]        power_db;
    logic                      zero_mag;
    logic signed [PHASE_W-1:0] phase;
    logic                      last;
  } fbp_result_t;

  // Index of the highest set bit of a byte, zero for an empty byte.
  function automatic logic [2:0] msb8(input logic [7:0] v);
    logic [2:0] pos;
    pos = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (v[k]) begin
        pos = 3'(k);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> sv/fbp_power.sv
`default_nettype none

module fbp_power #(
  parameter int COMPONENT_BITS = fbp_pkg::COMPONENT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [fbp_pkg::IN_W-1:0]     in_real,
  input  logic [fbp_pkg::IN_W-1:0]     in_imag,
  output logic                         out_valid,
  output logic [fbp_pkg::POWER_W-1:0]  out_power
);

  localparam int CB        = COMPONENT_BITS;
  localparam int SQ_W      = 2 * CB;
  localparam int MAG_W     = fbp_pkg::MAG_W;
  localparam int MANT_W    = fbp_pkg::MANT_W;
  localparam int EXP_W     = fbp_pkg::EXP_W;
  localparam int FRAC_W    = fbp_pkg::FRAC_W;
  localparam int LOG_W     = fbp_pkg::LOG_W;
  localparam int DB_PROD_W = fbp_pkg::DB_PROD_W;
  localparam int POWER_W   = fbp_pkg::POWER_W;

  // Stage 1: magnitudes of both components.
  logic [CB-1:0] re_u, im_u;
  logic [CB-1:0] abs_re_nxt, abs_im_nxt, abs_re_r, abs_im_r;
  logic          v1_r;

  assign re_u = in_real[CB-1:0];
  assign im_u = in_imag[CB-1:0];
  assign abs_re_nxt = re_u[CB-1] ? ((~re_u) + CB'(1)) : re_u;
  assign abs_im_nxt = im_u[CB-1] ? ((~im_u) + CB'(1)) : im_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abs_re_r <= abs_re_nxt;
      abs_im_r <= abs_im_nxt;
    end
  end

  // Stage 2: squares.
  logic [SQ_W-1:0] sq_re_nxt, sq_im_nxt, sq_re_r, sq_im_r;
  logic            v2_r;

  assign sq_re_nxt = SQ_W'(abs_re_r) * SQ_W'(abs_re_r);
  assign sq_im_nxt = SQ_W'(abs_im_r) * SQ_W'(abs_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_re_r <= sq_re_nxt;
      sq_im_r <= sq_im_nxt;
    end
  end

  // Stage 3: squared magnitude; it cannot overflow the square width.
  logic [MAG_W-1:0] mag_nxt, mag_r;
  logic             v3_r;

  assign mag_nxt = MAG_W'(sq_re_r) + MAG_W'(sq_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
    end
  end

  // Stage 4: find the top nonzero byte and shift it to the top.
  logic [7:0]       grp_nz;
  logic [2:0]       grp_nxt, grp_r;
  logic [2:0]       grp_up;
  logic [5:0]       grp_shamt;
  logic [MAG_W-1:0] mm_nxt, mm_r;
  logic             v4_r;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      grp_nz[k] = |mag_r[8*k +: 8];
    end
  end

  assign grp_nxt   = fbp_pkg::msb8(grp_nz);
  assign grp_up    = 3'd7 - grp_nxt;
  assign grp_shamt = {grp_up, 3'b000};
  assign mm_nxt    = mag_r << grp_shamt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r <= grp_nxt;
      mm_r  <= mm_nxt;
    end
  end

  // Stage 5: finish the left justification; exponent and Q1.31 mantissa.
  logic [2:0]       bpos;
  logic [2:0]       bit_shamt;
  logic [MAG_W-1:0] norm;

  // Log2 fraction pipeline, one squaring per stage; entry 0 is stage 5.
  logic [MANT_W-1:0] lx_r [0:FRAC_W];
  logic [FRAC_W-1:0] lf_r [0:FRAC_W];
  logic [EXP_W-1:0]  le_r [0:FRAC_W];
  logic              lv_r [0:FRAC_W];

  assign bpos      = fbp_pkg::msb8(mm_r[MAG_W-1 -: 8]);
  assign bit_shamt = 3'd7 - bpos;
  assign norm      = mm_r << bit_shamt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r[0] <= 1'b0;
    end else if (en) begin
      lv_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lx_r[0] <= norm[MAG_W-1 -: MANT_W];
      lf_r[0] <= '0;
      le_r[0] <= {grp_r, bpos};
    end
  end

  // Each step squares the mantissa; a square of 2.0 or more gives a one bit.
  for (genvar k = 0; k < FRAC_W; k++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic                hi;
    logic [MANT_W-1:0]   x_nxt;

    assign sq    = (2*MANT_W)'(lx_r[k]) * (2*MANT_W)'(lx_r[k]);
    assign hi    = sq[2*MANT_W-1];
    assign x_nxt = hi ? sq[2*MANT_W-1 -: MANT_W] : sq[2*MANT_W-2 -: MANT_W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lv_r[k+1] <= 1'b0;
      end else if (en) begin
        lv_r[k+1] <= lv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lx_r[k+1] <= x_nxt;
        lf_r[k+1] <= {lf_r[k][FRAC_W-2:0], hi};
        le_r[k+1] <= le_r[k];
      end
    end
  end

  // Log2 to decibels: scale by 10*log10(2) in Q24.
  logic [LOG_W-1:0]     log_val;
  logic [DB_PROD_W-1:0] db_prod_nxt, db_prod_r;
  logic                 v22_r;

  assign log_val     = {le_r[FRAC_W], lf_r[FRAC_W]};
  assign db_prod_nxt = DB_PROD_W'(log_val) * DB_PROD_W'(fbp_pkg::DB_PER_LOG2_Q24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v22_r <= 1'b0;
    end else if (en) begin
      v22_r <= lv_r[FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      db_prod_r <= db_prod_nxt;
    end
  end

  // Round to Q8.8.
  logic [DB_PROD_W-1:0] db_sum;
  logic [POWER_W-1:0]   power_nxt, power_r;
  logic                 v23_r;

  assign db_sum    = db_prod_r + fbp_pkg::DB_ROUND;
  assign power_nxt = db_sum[fbp_pkg::DB_DROP +: POWER_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v23_r <= 1'b0;
    end else if (en) begin
      v23_r <= v22_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      power_r <= power_nxt;
    end
  end

  assign out_valid = v23_r;
  assign out_power = power_r;

endmodule

`default_nettype wire

>>> sv/fbp_phase.sv
`default_nettype none

module fbp_phase #(
  parameter int COMPONENT_BITS = fbp_pkg::COMPONENT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [fbp_pkg::IN_W-1:0] in_real,
  input  logic [fbp_pkg::IN_W-1:0] in_imag,
  input  logic                     in_last,
  output logic                     out_valid,
  output fbp_pkg::fbp_ph_res_t     out_res
);

  localparam int CB      = COMPONENT_BITS;
  localparam int A_W     = fbp_pkg::A_W;
  localparam int SHIFT_W = fbp_pkg::SHIFT_W;
  localparam int CW      = fbp_pkg::CW;
  localparam int ACC_W   = fbp_pkg::ACC_W;
  localparam int STEPS   = fbp_pkg::CORDIC_STEPS;
  localparam int PHASE_W = fbp_pkg::PHASE_W;

  // Stage 1: fold the left half plane onto the right half plane.
  logic signed [CB-1:0] re_s, im_s;
  logic signed [CB:0]   re_e, im_e;
  logic signed [CB:0]   x1_nxt, y1_nxt, x1_r, y1_r;
  logic                 neg1_r, zero1_r, last1_r, v1_r;

  assign re_s   = in_real[CB-1:0];
  assign im_s   = in_imag[CB-1:0];
  assign re_e   = {re_s[CB-1], re_s};
  assign im_e   = {im_s[CB-1], im_s};
  assign x1_nxt = re_s[CB-1] ? -re_e : re_e;
  assign y1_nxt = re_s[CB-1] ? -im_e : im_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x1_nxt;
      y1_r    <= y1_nxt;
      neg1_r  <= re_s[CB-1];
      zero1_r <= (re_s == '0) && (im_s == '0);
      last1_r <= in_last;
    end
  end

  // Stage 2: larger of the two magnitudes; x is never negative here.
  logic signed [CB:0] ay_full;
  logic [CB-1:0]      ax, ay, a_nxt, a_r;
  logic signed [CB:0] x2_r, y2_r;
  logic               neg2_r, zero2_r, last2_r, v2_r;

  assign ay_full = y1_r[CB] ? -y1_r : y1_r;
  assign ax      = x1_r[CB-1:0];
  assign ay      = ay_full[CB-1:0];
  assign a_nxt   = (ax > ay) ? ax : ay;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= a_nxt;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      neg2_r  <= neg1_r;
      zero2_r <= zero1_r;
      last2_r <= last1_r;
    end
  end

  // Stage 3: coarse search for the leading one, a byte at a time.
  logic [A_W-1:0]     a_ext, a_sh;
  logic [3:0]         a_grp_nz;
  logic [2:0]         g_full;
  logic [1:0]         g_nxt, g_up, g_r;
  logic [4:0]         g_shamt;
  logic [7:0]         tb_nxt, tb_r;
  logic signed [CB:0] x3_r, y3_r;
  logic               neg3_r, zero3_r, last3_r, v3_r;

  assign a_ext = A_W'(a_r);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a_grp_nz[k] = |a_ext[8*k +: 8];
    end
  end

  assign g_full  = fbp_pkg::msb8({4'b0000, a_grp_nz});
  assign g_nxt   = g_full[1:0];
  assign g_up    = 2'd3 - g_nxt;
  assign g_shamt = {g_up, 3'b000};
  assign a_sh    = a_ext << g_shamt;
  assign tb_nxt  = a_sh[A_W-1 -: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r     <= g_nxt;
      tb_r    <= tb_nxt;
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
      last3_r <= last2_r;
    end
  end

  // Stage 4: shift that lifts the larger magnitude to at least 2^30.
  logic [2:0]         b_pos;
  logic [4:0]         lead;
  logic [SHIFT_W-1:0] s_nxt, s_r;
  logic signed [CB:0] x4_r, y4_r;
  logic               neg4_r, zero4_r, last4_r, v4_r;

  assign b_pos = fbp_pkg::msb8(tb_r);
  assign lead  = {g_r, b_pos};
  assign s_nxt = (lead >= fbp_pkg::NORM_TOP) ? '0 : (fbp_pkg::NORM_TOP - lead);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r     <= s_nxt;
      x4_r    <= x3_r;
      y4_r    <= y3_r;
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
      last4_r <= last3_r;
    end
  end

  // CORDIC pipeline; entry 0 is stage 5, which applies the scaling shift.
  logic signed [CW-1:0]    cx_r [0:STEPS];
  logic signed [CW-1:0]    cy_r [0:STEPS];
  logic signed [ACC_W-1:0] ca_r [0:STEPS];
  logic                    cz_r [0:STEPS];
  logic                    cl_r [0:STEPS];
  logic                    cv_r [0:STEPS];

  logic signed [CW-1:0] x_ext, y_ext;

  assign x_ext = {{(CW-CB-1){x4_r[CB]}}, x4_r};
  assign y_ext = {{(CW-CB-1){y4_r[CB]}}, y4_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= x_ext <<< s_r;
      cy_r[0] <= y_ext <<< s_r;
      ca_r[0] <= neg4_r ? fbp_pkg::ANGLE_PI : '0;
      cz_r[0] <= zero4_r;
      cl_r[0] <= last4_r;
    end
  end

  // One vectoring step per stage, driving y toward zero.
  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    logic                    up;
    logic signed [CW-1:0]    x_nxt, y_nxt;
    logic signed [ACC_W-1:0] acc_nxt;

    assign up      = ~cy_r[i][CW-1];
    assign x_nxt   = up ? (cx_r[i] + (cy_r[i] >>> i)) : (cx_r[i] - (cy_r[i] >>> i));
    assign y_nxt   = up ? (cy_r[i] - (cx_r[i] >>> i)) : (cy_r[i] + (cx_r[i] >>> i));
    assign acc_nxt = up ? (ca_r[i] + fbp_pkg::ATAN_TAB[i])
                        : (ca_r[i] - fbp_pkg::ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (en) begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i+1] <= x_nxt;
        cy_r[i+1] <= y_nxt;
        ca_r[i+1] <= acc_nxt;
        cz_r[i+1] <= cz_r[i];
        cl_r[i+1] <= cl_r[i];
      end
    end
  end

  // Final stage: round the angle to 16 bits; it wraps modulo pi, so plus pi gives zero.
  logic signed [ACC_W-1:0] acc_rnd;
  fbp_pkg::fbp_ph_res_t    res_nxt, res_r;
  logic                    vo_r;

  assign acc_rnd = ca_r[STEPS] + fbp_pkg::ACC_ROUND;

  always_comb begin
    res_nxt.zero_mag = cz_r[STEPS];
    res_nxt.last     = cl_r[STEPS];
    res_nxt.phase    = acc_rnd[fbp_pkg::PH_DROP +: PHASE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= cv_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

>>> sv/fbp_outbuf.sv
`default_nettype none

module fbp_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pipe_valid,
  input  fbp_pkg::fbp_result_t pipe_data,
  output logic                 en,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fbp_pkg::fbp_result_t out_data
);

  logic                 out_v_nxt, out_v_r;
  logic                 skid_v_nxt, skid_v_r;
  logic                 load_out, load_skid, take;
  fbp_pkg::fbp_result_t out_d_nxt, out_d_r, skid_d_r;

  // The pipeline advances as long as the skid register is free.
  assign en   = ~skid_v_r;
  assign take = out_v_r & ~out_stall;

  // Route the item leaving the pipeline to the output or the skid register.
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    if (skid_v_r) begin
      if (take) begin
        load_out   = 1'b1;
        skid_v_nxt = 1'b0;
      end
    end else if (pipe_valid) begin
      if (!out_v_r || take) begin
        load_out  = 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  assign out_d_nxt = skid_v_r ? skid_d_r : pipe_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_d_r <= out_d_nxt;
    end
    if (load_skid) begin
      skid_d_r <= pipe_data;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

`default_nettype wire

>>> sv/fft_bin_log_power_and_phase.sv
`default_nettype none

// Channel  Dir  Payload                                     Handshake
// in       in   in_bin_real, in_bin_imag, in_bin_last       in_valid / in_stall
// out      out  out_power_db, out_zero_magnitude,           out_valid / out_stall
//               out_phase_angle, out_last_out
//
// One item is taken every clock while in_stall is low. Its result passes 30 pipeline
// stages, set by the 24 CORDIC steps of the phase path, and then the output register.
// The shorter power path is delayed by PAD registers to line up with the phase.
// rst_n (synchronous) clears all valid bits, those of the output and skid register too.
// in_stall is high only while the skid register holds an item; the whole
// pipeline then holds its contents.

module fft_bin_log_power_and_phase #(
  parameter int COMPONENT_BITS = fbp_pkg::COMPONENT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [fbp_pkg::IN_W-1:0]    in_bin_real,
  input  logic signed [fbp_pkg::IN_W-1:0]    in_bin_imag,
  input  logic                               in_bin_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fbp_pkg::POWER_W-1:0]        out_power_db,
  output logic                               out_zero_magnitude,
  output logic signed [fbp_pkg::PHASE_W-1:0] out_phase_angle,
  output logic                               out_last_out
);

  localparam int PAD     = fbp_pkg::PAD;
  localparam int POWER_W = fbp_pkg::POWER_W;

  logic                   en;
  logic                   pw_valid, ph_valid;
  logic [POWER_W-1:0]     pw_power;
  fbp_pkg::fbp_ph_res_t   ph_res;
  fbp_pkg::fbp_result_t   res, out_data;

  fbp_power #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_power (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_real   (in_bin_real),
    .in_imag   (in_bin_imag),
    .out_valid (pw_valid),
    .out_power (pw_power)
  );

  fbp_phase #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_real   (in_bin_real),
    .in_imag   (in_bin_imag),
    .in_last   (in_bin_last),
    .out_valid (ph_valid),
    .out_res   (ph_res)
  );

  // Delay line that aligns the power result with the phase result.
  logic [POWER_W-1:0] pad_pw_r [PAD];
  logic               pad_v_r  [PAD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PAD; k++) begin
        pad_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      pad_v_r[0] <= pw_valid;
      for (int k = 1; k < PAD; k++) begin
        pad_v_r[k] <= pad_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pad_pw_r[0] <= pw_power;
      for (int k = 1; k < PAD; k++) begin
        pad_pw_r[k] <= pad_pw_r[k-1];
      end
    end
  end

  // A zero bin reports zero power and zero phase.
  always_comb begin
    res.power_db = ph_res.zero_mag ? '0 : pad_pw_r[PAD-1];
    res.zero_mag = ph_res.zero_mag;
    res.phase    = ph_res.zero_mag ? '0 : ph_res.phase;
    res.last     = ph_res.last;
  end

  fbp_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .pipe_valid (ph_valid),
    .pipe_data  (res),
    .en         (en),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  assign in_stall           = ~en;
  assign out_power_db       = out_data.power_db;
  assign out_zero_magnitude = out_data.zero_mag;
  assign out_phase_angle    = out_data.phase;
  assign out_last_out       = out_data.last;

  // The two paths must deliver their halves of an item in the same cycle.
  a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    pad_v_r[PAD-1] == ph_valid)
    else $error("power and phase paths out of step");

  // The skid register only fills behind a held output.
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("skid register filled while output was free");

  // A zero bin must leave with both values cleared.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_magnitude) |-> (out_power_db == '0 && out_phase_angle == '0))
    else $error("zero bin with nonzero power or phase");

endmodule

`default_nettype wire
